// File: rtl/scfp_pkg.sv
package scfp_pkg;

  // Default accumulator width
  localparam int unsigned ValueBitsDefault = 32;

  // Width of the delivered value field
  localparam int unsigned ParamValueWidth = 32;

  // Byte codes
  localparam logic [7:0] DirLow    = 8'h41;
  localparam logic [7:0] DirHigh   = 8'h48;
  localparam logic [7:0] DirBase   = 8'h40;
  localparam logic [7:0] OpenBrace = 8'h7B;
  localparam logic [7:0] CloseBrace = 8'h7D;
  localparam logic [7:0] ReportCode = 8'h50;
  localparam logic [7:0] IgnoreId  = 8'h23;
  localparam logic [7:0] DigitBase = 8'd48;
  localparam logic [7:0] IdVelocity = 8'h30;
  localparam logic [7:0] IdKp      = 8'h31;
  localparam logic [7:0] IdKi      = 8'h32;

  // Frame positions of interest
  localparam logic [7:0] PosId    = 8'd1;
  localparam logic [7:0] PosThird = 8'd3;
  localparam logic [7:0] PosLimit = 8'd255;

  // Parameter select codes
  localparam logic [1:0] SelVelocity = 2'd0;
  localparam logic [1:0] SelKp       = 2'd1;
  localparam logic [1:0] SelKi       = 2'd2;
  localparam logic [1:0] SelReserved = 2'd3;

  // One result transaction
  typedef struct packed {
    logic [3:0]                        direction;
    logic                              param_valid;
    logic [1:0]                        param_select;
    logic signed [ParamValueWidth-1:0] param_value;
    logic                              report_request;
    logic                              value_saturated;
  } result_t;

endpackage

// File: rtl/scfp_sat_fold.sv
module scfp_sat_fold #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic signed [VALUE_BITS-1:0] acc_i,
  input  logic signed [8:0]            digit_i,
  output logic signed [VALUE_BITS-1:0] acc_o,
  output logic                         sat_o
);

  localparam int unsigned WideBits = VALUE_BITS + 5;

  localparam logic signed [WideBits-1:0] ValMax = {6'b000000, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [WideBits-1:0] ValMin = {6'b111111, {(VALUE_BITS-1){1'b0}}};

  logic signed [WideBits-1:0] acc_wide;
  logic signed [WideBits-1:0] digit_wide;
  logic signed [WideBits-1:0] sum;

  // Form acc*10 + digit exactly, by shifts and adds
  assign acc_wide   = WideBits'(acc_i);
  assign digit_wide = WideBits'(digit_i);
  assign sum        = (acc_wide <<< 3) + (acc_wide <<< 1) + digit_wide;

  // Clamp to the signed limits
  always_comb begin
    if (sum > ValMax) begin
      acc_o = ValMax[VALUE_BITS-1:0];
      sat_o = 1'b1;
    end else if (sum < ValMin) begin
      acc_o = ValMin[VALUE_BITS-1:0];
      sat_o = 1'b1;
    end else begin
      acc_o = sum[VALUE_BITS-1:0];
      sat_o = 1'b0;
    end
  end

endmodule

// File: rtl/scfp_core.sv
module scfp_core #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output scfp_pkg::result_t result_o
);

  import scfp_pkg::*;

  logic                         in_frame_q, in_frame_d;
  logic [7:0]                   position_q, position_d;
  logic [7:0]                   id_byte_q, id_byte_d;
  logic [7:0]                   third_byte_q, third_byte_d;
  logic signed [VALUE_BITS-1:0] acc_q, acc_d;
  logic                         sat_seen_q, sat_seen_d;

  logic signed [8:0]            digit;
  logic signed [VALUE_BITS-1:0] acc_fold;
  logic                         fold_sat;
  logic signed [63:0]           acc_ext;
  logic                         frame_active;
  logic [1:0]                   sel;

  // Digit value without range check
  assign digit = signed'({1'b0, rx_byte_i} - {1'b0, DigitBase});

  scfp_sat_fold #(
    .VALUE_BITS(VALUE_BITS)
  ) u_fold (
    .acc_i  (acc_q),
    .digit_i(digit),
    .acc_o  (acc_fold),
    .sat_o  (fold_sat)
  );

  assign acc_ext      = 64'(acc_q);
  assign frame_active = in_frame_q || (rx_byte_i == OpenBrace);

  // Decode parameter id
  always_comb begin
    unique case (id_byte_q)
      IdVelocity: sel = SelVelocity;
      IdKp:       sel = SelKp;
      IdKi:       sel = SelKi;
      default:    sel = SelReserved;
    endcase
  end

  // Build the result of this byte
  always_comb begin
    result_o = '0;
    if (rx_byte_i >= DirLow && rx_byte_i <= DirHigh) begin
      result_o.direction = 4'(rx_byte_i - DirBase);
    end
    if (rx_byte_i == CloseBrace) begin
      if (third_byte_q == ReportCode) begin
        result_o.report_request = 1'b1;
      end else if (id_byte_q != IgnoreId) begin
        result_o.param_valid     = 1'b1;
        result_o.param_select    = sel;
        result_o.param_value     = acc_ext[ParamValueWidth-1:0];
        result_o.value_saturated = sat_seen_q;
      end
    end
  end

  // Advance frame state
  always_comb begin
    in_frame_d   = in_frame_q;
    position_d   = position_q;
    id_byte_d    = id_byte_q;
    third_byte_d = third_byte_q;
    acc_d        = acc_q;
    sat_seen_d   = sat_seen_q;
    if (rx_byte_i == CloseBrace) begin
      in_frame_d   = 1'b0;
      position_d   = '0;
      id_byte_d    = '0;
      third_byte_d = '0;
      acc_d        = '0;
      sat_seen_d   = 1'b0;
    end else if (frame_active) begin
      in_frame_d = 1'b1;
      if (position_q == PosId) begin
        id_byte_d = rx_byte_i;
      end
      if (position_q == PosThird) begin
        third_byte_d = rx_byte_i;
      end
      if (position_q >= PosThird) begin
        acc_d      = acc_fold;
        sat_seen_d = sat_seen_q | fold_sat;
      end
      if (position_q != PosLimit) begin
        position_d = position_q + 8'd1;
      end
    end
  end

  // Hold frame state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      position_q   <= '0;
      id_byte_q    <= '0;
      third_byte_q <= '0;
      acc_q        <= '0;
      sat_seen_q   <= 1'b0;
    end else if (accept_i) begin
      in_frame_q   <= in_frame_d;
      position_q   <= position_d;
      id_byte_q    <= id_byte_d;
      third_byte_q <= third_byte_d;
      acc_q        <= acc_d;
      sat_seen_q   <= sat_seen_d;
    end
  end

endmodule

// File: rtl/scfp_out_buf.sv
module scfp_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  scfp_pkg::result_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output scfp_pkg::result_t pop_data_o
);

  import scfp_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_data_q, main_data_d;
  result_t skid_data_q, skid_data_d;
  logic    push;
  logic    pop;

  assign push_ready_o = !skid_valid_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = main_valid_q && pop_ready_i;
  assign pop_valid_o  = main_valid_q;
  assign pop_data_o   = main_data_q;

  // Steer results between output and skid slots
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_data_d  = main_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_data_d  = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      main_valid_d = 1'b1;
      if (!main_valid_q || pop) begin
        main_data_d = push_data_i;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  // Hold slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Hold slot payloads
  always_ff @(posedge clk_i) begin
    main_data_q <= main_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

// File: rtl/serial_command_frame_parser_unit.sv
// Channel | Dir | Handshake                 | Payload
// --------+-----+---------------------------+---------------------------------------------
// input   | in  | in_valid_i / in_ready_o   | rx_byte_i
// result  | out | out_valid_o / out_ready_i | direction_o to value_saturated_o (six ports)
//
// Frame state and the saturating decimal fold update at the accepting edge, and the result
// is written at that same edge into the output register, or into the skid slot when that
// register is full; out_valid_o offers the result held in the output register.
// One byte per cycle is sustained while out_ready_i is high; a two-slot output buffer
// takes one more byte while a result waits, then in_ready_o drops until one result leaves.
// Reset clears the frame state and empties the output buffer.
module serial_command_frame_parser_unit #(
  parameter int unsigned VALUE_BITS = scfp_pkg::ValueBitsDefault
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic [7:0]                                   rx_byte_i,
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic [3:0]                                   direction_o,
  output logic                                         param_valid_o,
  output logic [1:0]                                   param_select_o,
  output logic signed [scfp_pkg::ParamValueWidth-1:0]  param_value_o,
  output logic                                         report_request_o,
  output logic                                         value_saturated_o
);

  import scfp_pkg::*;

  result_t core_result;
  result_t out_result;
  logic    accept;

  assign accept = in_valid_i && in_ready_o;

  // Parse one byte per transaction
  scfp_core #(
    .VALUE_BITS(VALUE_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .result_o (core_result)
  );

  // Register and buffer results
  scfp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(in_valid_i),
    .push_ready_o(in_ready_o),
    .push_data_i (core_result),
    .pop_valid_o (out_valid_o),
    .pop_ready_i (out_ready_i),
    .pop_data_o  (out_result)
  );

  assign direction_o       = out_result.direction;
  assign param_valid_o     = out_result.param_valid;
  assign param_select_o    = out_result.param_select;
  assign param_value_o     = out_result.param_value;
  assign report_request_o  = out_result.report_request;
  assign value_saturated_o = out_result.value_saturated;

endmodule

// File: tb/serial_command_frame_parser_unit_tb.sv
`timescale 1ns / 1ps

module serial_command_frame_parser_unit_tb;
  import scfp_pkg::*;

  localparam int     WatchdogLimit = 5000;
  localparam longint AccMax = (longint'(1) <<< (ValueBitsDefault - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_ready_o;
  logic [7:0]                        rx_byte_i;
  logic                              out_valid_o;
  logic                              out_ready_i;
  logic [3:0]                        direction_o;
  logic                              param_valid_o;
  logic [1:0]                        param_select_o;
  logic signed [ParamValueWidth-1:0] param_value_o;
  logic                              report_request_o;
  logic                              value_saturated_o;

  // Bytes waiting to be sent and results still owed by the parser
  logic [7:0] pending_bytes[$];
  result_t    owed_results[$];

  // Frame state mirrored from the parser
  logic       frame_open  = 1'b0;
  logic [7:0] frame_pos   = '0;
  logic [7:0] frame_id    = '0;
  logic [7:0] frame_third = '0;
  longint     frame_acc   = 0;
  logic       frame_sat   = 1'b0;

  int  bytes_sent    = 0;
  int  results_seen  = 0;
  int  updates_seen  = 0;
  int  reports_seen  = 0;
  int  sat_seen_cnt  = 0;
  int  error_count   = 0;
  int  idle_cycles   = 0;
  logic steady;

  serial_command_frame_parser_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .direction_o       (direction_o),
    .param_valid_o     (param_valid_o),
    .param_select_o    (param_select_o),
    .param_value_o     (param_value_o),
    .report_request_o  (report_request_o),
    .value_saturated_o (value_saturated_o)
  );

  // Fold one byte into the mirrored frame state and give the expected result
  function automatic result_t parse_byte(logic [7:0] b);
    result_t r;
    longint  t;
    r = '0;
    if (b >= DirLow && b <= DirHigh) r.direction = 4'(b - DirBase);
    if (b == OpenBrace) frame_open = 1'b1;
    if (b == CloseBrace) begin
      if (frame_third == ReportCode) begin
        r.report_request = 1'b1;
      end else if (frame_id != IgnoreId) begin
        r.param_valid = 1'b1;
        case (frame_id)
          IdVelocity: r.param_select = SelVelocity;
          IdKp:       r.param_select = SelKp;
          IdKi:       r.param_select = SelKi;
          default:    r.param_select = SelReserved;
        endcase
        r.param_value     = frame_acc[ParamValueWidth-1:0];
        r.value_saturated = frame_sat;
      end
      frame_open  = 1'b0;
      frame_pos   = '0;
      frame_id    = '0;
      frame_third = '0;
      frame_acc   = 0;
      frame_sat   = 1'b0;
      return r;
    end
    if (frame_open) begin
      if (frame_pos == PosId) frame_id = b;
      if (frame_pos == PosThird) frame_third = b;
      if (frame_pos >= PosThird) begin
        t = frame_acc * 10 + (longint'(b) - longint'(DigitBase));
        if (t > AccMax) begin
          t = AccMax;
          frame_sat = 1'b1;
        end else if (t < AccMin) begin
          t = AccMin;
          frame_sat = 1'b1;
        end
        frame_acc = t;
      end
      if (frame_pos != PosLimit) frame_pos++;
    end
    return r;
  endfunction

  // Digit-like byte, biased towards overflow, underflow or junk by mode
  function automatic logic [7:0] pick_digit(int mode);
    logic [7:0] d;
    d = DigitBase + 8'($urandom_range(0, 9));
    case (mode)
      1: if ($urandom_range(0, 99) < 90) d = DigitBase + 8'd9;
      2: if ($urandom_range(0, 99) < 80) d = 8'h00;
         else d = 8'($urandom_range(0, 255));
      3: if ($urandom_range(0, 99) < 30) d = 8'($urandom_range(0, 255));
      default: ;
    endcase
    return d;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Back-to-back traffic on both sides for one stretch of the run
  assign steady = (bytes_sent >= 400) && (bytes_sent < 700);

  // Driver: hold the byte until accepted, then advance or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        owed_results.push_back(parse_byte(rx_byte_i));
        bytes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_bytes.size() > 0 && (steady || $urandom_range(0, 99) >= 33)) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= pending_bytes.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(0, 99) >= 33);
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, direction %0h", $time, direction_o);
        end else begin
          want = owed_results.pop_front();
          check_field("direction", 32'(want.direction), 32'(direction_o));
          check_field("param_valid", 32'(want.param_valid), 32'(param_valid_o));
          check_field("param_select", 32'(want.param_select), 32'(param_select_o));
          check_field("param_value", want.param_value, param_value_o);
          check_field("report_request", 32'(want.report_request), 32'(report_request_o));
          check_field("value_saturated", 32'(want.value_saturated),
                      32'(value_saturated_o));
          if (want.param_valid) updates_seen++;
          if (want.report_request) reports_seen++;
          if (want.value_saturated) sat_seen_cnt++;
        end
      end
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, WatchdogLimit);
        $display("serial_command_frame_parser_unit_tb NOT OK");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [7:0] body[$];
    int         mode;
    int         ndig;
    int         n;
    int         long_count;

    rst_ni     = 1'b0;
    long_count = 0;

    // Direction range and its edges, a close with no frame, one update,
    // one report and one ignored id
    pending_bytes = '{DirLow, DirHigh, DirBase, 8'h49, 8'h00, 8'hFF, CloseBrace,
                      OpenBrace, IdVelocity, "x", "1", "2", CloseBrace,
                      OpenBrace, IdKp, "a", ReportCode, CloseBrace,
                      OpenBrace, IgnoreId, "a", "5", CloseBrace};

    while (pending_bytes.size() < 1250) begin
      n = $urandom_range(0, 99);
      if (long_count < 2 && pending_bytes.size() > 400 + long_count * 500) begin
        // Long frame: position pins at its limit while the fold carries on
        pending_bytes.push_back(OpenBrace);
        pending_bytes.push_back(long_count == 0 ? IdKi : IdVelocity);
        repeat (265) pending_bytes.push_back(pick_digit(long_count == 0 ? 0 : 3));
        pending_bytes.push_back(CloseBrace);
        long_count++;
      end else if (n < 12) begin
        // Noise between frames
        repeat ($urandom_range(1, 4)) begin
          n = $urandom_range(0, 99);
          if (n < 40) pending_bytes.push_back(DirBase + 8'($urandom_range(0, 9)));
          else if (n < 50) pending_bytes.push_back(CloseBrace);
          else pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
      end else if (n < 18) begin
        // Open a frame and abandon it
        pending_bytes.push_back(OpenBrace);
        repeat ($urandom_range(0, 4)) pending_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        // Well-formed frame with random content
        body.delete();
        mode = $urandom_range(0, 3);
        case ($urandom_range(0, 5))
          0: body.push_back(IdVelocity);
          1: body.push_back(IdKp);
          2: body.push_back(IdKi);
          3: body.push_back(IgnoreId);
          4: body.push_back(ReportCode);
          default: body.push_back(8'($urandom_range(0, 255)));
        endcase
        body.push_back(8'($urandom_range(0, 255)));
        body.push_back($urandom_range(0, 99) < 15 ? ReportCode : pick_digit(mode));
        ndig = ($urandom_range(0, 99) < 25) ? $urandom_range(9, 14) : $urandom_range(0, 6);
        repeat (ndig) body.push_back(pick_digit(mode));
        if ($urandom_range(0, 99) < 8) body.insert($urandom_range(0, body.size()), OpenBrace);
        if ($urandom_range(0, 99) < 10) begin
          ndig = $urandom_range(0, 3);
          while (body.size() > ndig) void'(body.pop_back());
        end
        pending_bytes.push_back(OpenBrace);
        foreach (body[i]) pending_bytes.push_back(body[i]);
        pending_bytes.push_back(CloseBrace);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every byte sent and every result returned
    while (pending_bytes.size() != 0 || in_valid_i || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes, checked %0d results: %0d updates, %0d reports, %0d saturated.",
             bytes_sent, results_seen, updates_seen, reports_seen, sat_seen_cnt);
    if (error_count == 0) begin
      $display("serial_command_frame_parser_unit_tb OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("serial_command_frame_parser_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/scfp_pkg.sv
rtl/scfp_sat_fold.sv
rtl/scfp_core.sv
rtl/scfp_out_buf.sv
rtl/serial_command_frame_parser_unit.sv
tb/serial_command_frame_parser_unit_tb.sv
